// ===== hdl/wpcd_pkg.sv =====
// ----------------------------------------------------------------------------
// wpcd_pkg: shared types and constants
// Field widths, register codes and the settings bundle passed from the
// register file to the peak datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package wpcd_pkg;

  localparam int FRAME_W     = 31;
  localparam int COLUMN_W    = 11;
  localparam int CHANNEL_W   = 4;
  localparam int PROD_W      = 43;
  localparam int CFG_DATA_W  = 31;
  localparam int CFG_INDEX_W = 2;

  // register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_COUNT   = 2'd0,
    REG_COLUMN_COUNT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } cfg_reg_t;

  // effective (saturated) settings plus a clip restart strobe
  typedef struct packed {
    logic                 restart;
    logic [FRAME_W-1:0]   frames;
    logic [COLUMN_W-1:0]  columns;
    logic [CHANNEL_W-1:0] channels;
  } settings_t;

endpackage

`default_nettype wire

// ===== hdl/wpcd_in_if.sv =====
// ----------------------------------------------------------------------------
// wpcd_in_if: sample input channel
// Valid/ready channel carrying one signed channel sample per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpcd_in_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== hdl/wpcd_out_if.sv =====
// ----------------------------------------------------------------------------
// wpcd_out_if: column result channel
// Valid/ready channel carrying one closed column per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpcd_out_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                           valid;
  logic                           ready;
  logic [wpcd_pkg::COLUMN_W-1:0]  column_index;
  logic [SAMPLE_BITS-1:0]         peak;
  logic                           last_column;

  modport source (output valid, output column_index, output peak, output last_column,
                  input ready);
  modport sink   (input valid, input column_index, input peak, input last_column,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/wpcd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// wpcd_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpcd_cfg_if ();
  logic                            valid;
  logic                            ready;
  logic [wpcd_pkg::CFG_INDEX_W-1:0] index;
  logic [wpcd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/wpcd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// wpcd_cfg_regs: configuration registers
// Holds the raw register values and derives the saturated frame, column and
// channel counts; any write of a known register raises a restart strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module wpcd_cfg_regs #(
  parameter int MAX_COLUMNS  = 2000,
  parameter int MAX_CHANNELS = 8
) (
  input  wire                  clk,
  input  wire                  rst_n,
  wpcd_cfg_if.sink             cfg_ch,
  output wpcd_pkg::settings_t  settings
);

  logic [wpcd_pkg::FRAME_W-1:0]   frame_count_r,   frame_count_nxt;
  logic [wpcd_pkg::COLUMN_W-1:0]  column_count_r,  column_count_nxt;
  logic [wpcd_pkg::CHANNEL_W-1:0] channel_count_r, channel_count_nxt;
  logic                           wr_hit;

  logic [wpcd_pkg::FRAME_W-1:0]   eff_frames;
  logic [wpcd_pkg::COLUMN_W-1:0]  eff_columns;
  logic [wpcd_pkg::CHANNEL_W-1:0] eff_channels;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    frame_count_nxt   = frame_count_r;
    column_count_nxt  = column_count_r;
    channel_count_nxt = channel_count_r;
    wr_hit            = 1'b0;
    if (cfg_ch.valid) begin
      case (wpcd_pkg::cfg_reg_t'(cfg_ch.index))
        wpcd_pkg::REG_FRAME_COUNT: begin
          frame_count_nxt = cfg_ch.data[wpcd_pkg::FRAME_W-1:0];
          wr_hit          = 1'b1;
        end
        wpcd_pkg::REG_COLUMN_COUNT: begin
          column_count_nxt = cfg_ch.data[wpcd_pkg::COLUMN_W-1:0];
          wr_hit           = 1'b1;
        end
        wpcd_pkg::REG_CHANNEL_COUNT: begin
          channel_count_nxt = cfg_ch.data[wpcd_pkg::CHANNEL_W-1:0];
          wr_hit            = 1'b1;
        end
        default: wr_hit = 1'b0;
      endcase
    end
  end

  // saturation from the next values, so a restart sees the new settings
  always_comb begin
    eff_frames = (frame_count_nxt == '0) ? wpcd_pkg::FRAME_W'(1) : frame_count_nxt;

    eff_columns = (column_count_nxt == '0) ? wpcd_pkg::COLUMN_W'(1) : column_count_nxt;
    if (32'(eff_columns) > 32'(MAX_COLUMNS))
      eff_columns = wpcd_pkg::COLUMN_W'(MAX_COLUMNS);
    if (wpcd_pkg::FRAME_W'(eff_columns) > eff_frames)
      eff_columns = eff_frames[wpcd_pkg::COLUMN_W-1:0];

    eff_channels = (channel_count_nxt == '0) ? wpcd_pkg::CHANNEL_W'(1) : channel_count_nxt;
    if (32'(eff_channels) > 32'(MAX_CHANNELS))
      eff_channels = wpcd_pkg::CHANNEL_W'(MAX_CHANNELS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r   <= wpcd_pkg::FRAME_W'(1);
      column_count_r  <= wpcd_pkg::COLUMN_W'(1);
      channel_count_r <= wpcd_pkg::CHANNEL_W'(1);
    end else begin
      frame_count_r   <= frame_count_nxt;
      column_count_r  <= column_count_nxt;
      channel_count_r <= channel_count_nxt;
    end
  end

  assign settings.restart  = wr_hit;
  assign settings.frames   = eff_frames;
  assign settings.columns  = eff_columns;
  assign settings.channels = eff_channels;

endmodule

`default_nettype wire

// ===== hdl/wpcd_peak_core.sv =====
// ----------------------------------------------------------------------------
// wpcd_peak_core: peak envelope datapath
// Input register, magnitude and running max, column-end test on running
// products, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wpcd_peak_core #(
  parameter int SAMPLE_BITS  = 24,
  parameter int MAX_CHANNELS = 8
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wpcd_pkg::settings_t settings,
  wpcd_in_if.sink             in_ch,
  wpcd_out_if.source          out_ch
);

  localparam int CHPOS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // input stage
  logic                          s1_valid_r, s1_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;

  // clip state
  logic [SAMPLE_BITS-1:0]        peak_r,   peak_nxt;
  logic [wpcd_pkg::COLUMN_W-1:0] column_r, column_nxt;
  logic [CHPOS_W-1:0]            chpos_r,  chpos_nxt;
  logic [wpcd_pkg::PROD_W-1:0]   fprod_r,  fprod_nxt;
  logic [wpcd_pkg::PROD_W-1:0]   cprod_r,  cprod_nxt;

  // result stage
  logic                          out_valid_r, out_valid_nxt;
  logic [wpcd_pkg::COLUMN_W-1:0] out_index_r;
  logic [SAMPLE_BITS-1:0]        out_peak_r;
  logic                          out_last_r;

  logic                          adv;
  logic                          work;
  logic                          emit;
  logic                          is_last;
  logic [SAMPLE_BITS-1:0]        mag;
  logic [SAMPLE_BITS-1:0]        peak_upd;
  logic [CHPOS_W:0]              chpos_inc;
  logic [wpcd_pkg::PROD_W-1:0]   fprod_init;
  logic [wpcd_pkg::PROD_W-1:0]   cprod_init;

  assign adv         = !out_valid_r || out_ch.ready;
  assign work        = s1_valid_r && adv;
  assign in_ch.ready = !s1_valid_r || adv;

  // most negative code negates to full scale, which still fits unsigned
  assign mag = s1_sample_r[SAMPLE_BITS-1] ? (~s1_sample_r + SAMPLE_BITS'(1))
                                          : s1_sample_r;
  assign peak_upd  = (mag > peak_r) ? mag : peak_r;
  assign chpos_inc = {1'b0, chpos_r} + (CHPOS_W + 1)'(1);
  assign is_last   = ({1'b0, column_r} + (wpcd_pkg::COLUMN_W + 1)'(1))
                     >= {1'b0, settings.columns};

  assign fprod_init = wpcd_pkg::PROD_W'({settings.columns, 1'b0});
  assign cprod_init = wpcd_pkg::PROD_W'(settings.frames);

  always_comb begin
    peak_nxt   = peak_r;
    column_nxt = column_r;
    chpos_nxt  = chpos_r;
    fprod_nxt  = fprod_r;
    cprod_nxt  = cprod_r;
    emit       = 1'b0;
    if (settings.restart) begin
      peak_nxt   = '0;
      column_nxt = '0;
      chpos_nxt  = '0;
      fprod_nxt  = fprod_init;
      cprod_nxt  = cprod_init;
    end else if (work) begin
      peak_nxt = peak_upd;
      if (32'(chpos_inc) < 32'(settings.channels)) begin
        chpos_nxt = chpos_inc[CHPOS_W-1:0];
      end else begin
        chpos_nxt = '0;
        if (!(cprod_r < fprod_r)) begin
          fprod_nxt = fprod_r + wpcd_pkg::PROD_W'(settings.columns);
        end else begin
          emit     = 1'b1;
          peak_nxt = '0;
          if (is_last) begin
            column_nxt = '0;
            fprod_nxt  = fprod_init;
            cprod_nxt  = cprod_init;
          end else begin
            column_nxt = column_r + wpcd_pkg::COLUMN_W'(1);
            cprod_nxt  = cprod_r + wpcd_pkg::PROD_W'(settings.frames);
            fprod_nxt  = fprod_r + wpcd_pkg::PROD_W'(settings.columns);
          end
        end
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ch.valid && in_ch.ready)
      s1_valid_nxt = 1'b1;
    else if (adv)
      s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (emit)
      out_valid_nxt = 1'b1;
    else if (out_ch.ready)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      peak_r      <= '0;
      column_r    <= '0;
      chpos_r     <= '0;
      fprod_r     <= wpcd_pkg::PROD_W'(2);
      cprod_r     <= wpcd_pkg::PROD_W'(1);
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      peak_r      <= peak_nxt;
      column_r    <= column_nxt;
      chpos_r     <= chpos_nxt;
      fprod_r     <= fprod_nxt;
      cprod_r     <= cprod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready)
      s1_sample_r <= in_ch.sample;
    if (emit) begin
      out_index_r <= column_r;
      out_peak_r  <= peak_upd;
      out_last_r  <= is_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.column_index = out_index_r;
  assign out_ch.peak         = out_peak_r;
  assign out_ch.last_column  = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/waveform_peak_column_decimator_unit.sv =====
// ----------------------------------------------------------------------------
// waveform_peak_column_decimator_unit: peak envelope column decimator
// Reduces a channel-interleaved clip to per-column absolute peaks for display.
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload                              | per request
//  ---------+-----------+--------------------------------------+------------------
//  in_ch    | sink      | sample (signed Q1.23)                | one channel sample
//  out_ch   | source    | column_index, peak, last_column      | one closed column
//  cfg_ch   | sink      | index, data                          | one register write
//
//  one sample per cycle sustained while out_ch is ready; a sample passes an input register and the
//  result register, and a column shows on out_ch from the result register
//  the input register can still take a sample while a column waits in the result
//  register; a stalled output holds both stages once the input register is full
//  cfg_ch is always ready; a write of a known register restarts the clip
//  rst_n (synchronous) loads frame, column and channel counts of one each
//
`default_nettype none

module waveform_peak_column_decimator_unit #(
  parameter int MAX_COLUMNS  = 2000,
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 24
) (
  input  wire        clk,
  input  wire        rst_n,
  wpcd_in_if.sink    in_ch,
  wpcd_out_if.source out_ch,
  wpcd_cfg_if.sink   cfg_ch
);

  // magnitude of the most negative sample, the largest legal peak
  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // saturated counts and restart strobe from the register file
  wpcd_pkg::settings_t settings;

  // register file: raw counts, saturation, restart on write
  wpcd_cfg_regs #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_ch   (cfg_ch),
    .settings (settings)
  );

  // datapath: input register, running max, product compare, result register
  wpcd_peak_core #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_peak_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .settings (settings),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // an empty result register never blocks new samples
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty result register");

  // peak never exceeds full scale
  a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.peak <= FULL_SCALE))
    else $error("peak above full scale");

  // no result survives reset
  a_reset_clears_out: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_ch.valid)
    else $error("result pending right after reset");

endmodule

`default_nettype wire
